### rtl/tlvp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlvp_pkg;

    localparam int POSITION_BITS_DEF = 32;

    // Record tags
    localparam logic [7:0] TAG_TRACES  = 8'h41;
    localparam logic [7:0] TAG_SAMPLES = 8'h42;
    localparam logic [7:0] TAG_CODING  = 8'h43;
    localparam logic [7:0] TAG_DATALEN = 8'h44;
    localparam logic [7:0] TAG_TITLE   = 8'h45;
    localparam logic [7:0] TAG_SCALE_X = 8'h4B;
    localparam logic [7:0] TAG_SCALE_Y = 8'h4C;
    localparam logic [7:0] TAG_END     = 8'h5F;

    localparam logic [6:0] MAX_LEN_BYTES = 7'd4;
    localparam logic [5:0] CODING_RESET  = 6'h01;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_LEN    = 3'd1,
        ST_PAST_END   = 3'd2,
        ST_NO_END     = 3'd3,
        ST_NO_SAMPLES = 3'd4,
        ST_BAD_SIZE   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        PH_TAG   = 3'd0,
        PH_LEN1  = 3'd1,
        PH_LENX  = 3'd2,
        PH_VALUE = 3'd3,
        PH_SKIP  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_I8  = 2'd0,
        KIND_I16 = 2'd1,
        KIND_I32 = 2'd2,
        KIND_F32 = 2'd3
    } sample_kind_t;

    typedef struct packed {
        status_t             status;
        logic [31:0]         block_offset;
        logic signed [31:0]  trace_count;
        logic signed [31:0]  sample_count;
        logic [3:0]          sample_bytes;
        sample_kind_t        sample_kind;
        logic signed [15:0]  data_len;
        logic [7:0]          title_bytes;
        logic signed [35:0]  trace_size;
        logic [31:0]         scale_x_bits;
        logic [31:0]         scale_y_bits;
    } result_t;

endpackage

`default_nettype wire

### rtl/tlvp_core.sv
`timescale 1ns / 1ps
`default_nettype none

module tlvp_core #(
    parameter int POSITION_BITS = tlvp_pkg::POSITION_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        header_byte,
    input  wire logic              stream_end,
    output logic                   res_valid,
    output tlvp_pkg::result_t      res
);
    import tlvp_pkg::*;

    localparam int PosExtW = (POSITION_BITS > 32) ? POSITION_BITS : 32;

    phase_t                   phase_reg, phase_upd, phase_next;
    logic [7:0]               tag_reg, tag_upd, tag_next;
    logic [31:0]              acc_reg, acc_upd, acc_next;
    logic [2:0]               left_reg, left_upd, left_next;
    logic [1:0]               idx_reg, idx_upd, idx_next;
    logic [31:0]              vi_reg, vi_upd, vi_next;
    logic [31:0]              cap_reg, cap_upd, cap_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_upd, pos_next;
    logic [31:0]              traces_reg, traces_upd, traces_next;
    logic [31:0]              samples_reg, samples_upd, samples_next;
    logic [5:0]               coding_reg, coding_upd, coding_next;
    logic [15:0]              datalen_reg, datalen_upd, datalen_next;
    logic [7:0]               title_reg, title_upd, title_next;
    logic [31:0]              scalex_reg, scalex_upd, scalex_next;
    logic [31:0]              scaley_reg, scaley_upd, scaley_next;

    logic                     emit;
    status_t                  emit_status;
    logic                     finish;
    logic [PosExtW-1:0]       pos_ext;
    logic [34:0]              prod;
    logic signed [36:0]       tsize;
    logic                     samples_bad;
    logic [3:0]               code_sz;
    sample_kind_t             code_kind;

    // Trace size from the registers as held; no capture happens on the end tag step.
    assign prod        = samples_reg[30:0] * coding_reg[3:0];
    assign tsize       = $signed({2'b00, prod}) + $signed({29'd0, title_reg})
                         + 37'($signed(datalen_reg));
    assign samples_bad = samples_reg[31] || (samples_reg == 32'd0);
    assign pos_ext     = PosExtW'(pos_upd);

    always_comb
    begin
        code_sz = cap_upd[3:0];
        if (cap_upd[4] && code_sz == 4'd4)
        begin
            code_kind = KIND_F32;
        end
        else if (code_sz == 4'd2)
        begin
            code_kind = KIND_I16;
        end
        else if (code_sz == 4'd4)
        begin
            code_kind = KIND_I32;
        end
        else
        begin
            code_kind = KIND_I8;
        end
    end

    always_comb
    begin
        phase_upd   = phase_reg;
        tag_upd     = tag_reg;
        acc_upd     = acc_reg;
        left_upd    = left_reg;
        idx_upd     = idx_reg;
        vi_upd      = vi_reg;
        cap_upd     = cap_reg;
        pos_upd     = pos_reg + POSITION_BITS'(1);
        traces_upd  = traces_reg;
        samples_upd = samples_reg;
        coding_upd  = coding_reg;
        datalen_upd = datalen_reg;
        title_upd   = title_reg;
        scalex_upd  = scalex_reg;
        scaley_upd  = scaley_reg;
        emit        = 1'b0;
        emit_status = ST_OK;
        finish      = 1'b0;

        unique case (phase_reg)
            PH_TAG:
            begin
                tag_upd = header_byte;
                if (stream_end)
                begin
                    emit        = 1'b1;
                    emit_status = ST_NO_END;
                end
                else
                begin
                    phase_upd = PH_LEN1;
                end
            end
            PH_LEN1:
            begin
                if (header_byte[7])
                begin
                    if (header_byte[6:0] == 7'd0 || header_byte[6:0] > MAX_LEN_BYTES
                        || stream_end)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_BAD_LEN;
                    end
                    else
                    begin
                        left_upd  = header_byte[2:0];
                        idx_upd   = 2'd0;
                        acc_upd   = 32'd0;
                        phase_upd = PH_LENX;
                    end
                end
                else
                begin
                    acc_upd = {24'd0, header_byte};
                    finish  = 1'b1;
                end
            end
            PH_LENX:
            begin
                acc_upd  = acc_reg | (32'(header_byte) << {idx_reg, 3'b000});
                idx_upd  = idx_reg + 2'd1;
                left_upd = left_reg - 3'd1;
                if (left_upd == 3'd0)
                begin
                    finish = 1'b1;
                end
                else if (stream_end)
                begin
                    emit        = 1'b1;
                    emit_status = ST_BAD_LEN;
                end
            end
            PH_VALUE:
            begin
                if (vi_reg[31:2] == 30'd0)
                begin
                    cap_upd = cap_reg | (32'(header_byte) << {vi_reg[1:0], 3'b000});
                end
                vi_upd = vi_reg + 32'd1;
                if (vi_upd == acc_reg)
                begin
                    unique case (tag_reg)
                        TAG_TRACES:  if (acc_reg >= 32'd4) traces_upd = cap_upd;
                        TAG_SAMPLES: if (acc_reg >= 32'd4) samples_upd = cap_upd;
                        TAG_CODING:
                        begin
                            if (acc_reg >= 32'd1)
                            begin
                                coding_upd = {code_kind, (code_sz == 4'd0) ? 4'd1 : code_sz};
                            end
                        end
                        TAG_DATALEN: if (acc_reg >= 32'd2) datalen_upd = cap_upd[15:0];
                        TAG_TITLE:   if (acc_reg >= 32'd1) title_upd = cap_upd[7:0];
                        TAG_SCALE_X: if (acc_reg >= 32'd4) scalex_upd = cap_upd;
                        TAG_SCALE_Y: if (acc_reg >= 32'd4) scaley_upd = cap_upd;
                        default:     ;
                    endcase
                    phase_upd = PH_TAG;
                    if (stream_end)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_NO_END;
                    end
                end
                else if (stream_end)
                begin
                    emit        = 1'b1;
                    emit_status = ST_PAST_END;
                end
            end
            PH_SKIP:
            begin
            end
            default:
            begin
            end
        endcase

        // Length field complete: close the header, step over an empty value or open one
        if (finish)
        begin
            if (tag_reg == TAG_END)
            begin
                emit = 1'b1;
                if (samples_bad)
                begin
                    emit_status = ST_NO_SAMPLES;
                end
                else if (tsize <= 37'sd0)
                begin
                    emit_status = ST_BAD_SIZE;
                end
                else
                begin
                    emit_status = ST_OK;
                end
            end
            else if (acc_upd == 32'd0)
            begin
                phase_upd = PH_TAG;
                if (stream_end)
                begin
                    emit        = 1'b1;
                    emit_status = ST_NO_END;
                end
            end
            else
            begin
                vi_upd    = 32'd0;
                cap_upd   = 32'd0;
                phase_upd = PH_VALUE;
                if (stream_end)
                begin
                    emit        = 1'b1;
                    emit_status = ST_PAST_END;
                end
            end
        end

        if (emit)
        begin
            phase_upd = PH_SKIP;
        end
    end

    // Result shows the registers with this beat's capture applied
    always_comb
    begin
        res_valid        = step && emit;
        res.status       = emit_status;
        res.block_offset = (emit_status == ST_OK) ? pos_ext[31:0] : 32'd0;
        res.trace_count  = traces_upd;
        res.sample_count = samples_upd;
        res.sample_bytes = coding_upd[3:0];
        res.sample_kind  = sample_kind_t'(coding_upd[5:4]);
        res.data_len     = datalen_upd;
        res.title_bytes  = title_upd;
        res.trace_size   = (emit_status == ST_OK) ? tsize[35:0] : 36'sd0;
        res.scale_x_bits = scalex_upd;
        res.scale_y_bits = scaley_upd;
    end

    // Advance on each beat; return everything to reset after the final byte
    always_comb
    begin
        if (step && stream_end)
        begin
            phase_next   = PH_TAG;
            tag_next     = 8'd0;
            acc_next     = 32'd0;
            left_next    = 3'd0;
            idx_next     = 2'd0;
            vi_next      = 32'd0;
            cap_next     = 32'd0;
            pos_next     = '0;
            traces_next  = 32'd0;
            samples_next = 32'd0;
            coding_next  = CODING_RESET;
            datalen_next = 16'd0;
            title_next   = 8'd0;
            scalex_next  = 32'd0;
            scaley_next  = 32'd0;
        end
        else if (step)
        begin
            phase_next   = phase_upd;
            tag_next     = tag_upd;
            acc_next     = acc_upd;
            left_next    = left_upd;
            idx_next     = idx_upd;
            vi_next      = vi_upd;
            cap_next     = cap_upd;
            pos_next     = pos_upd;
            traces_next  = traces_upd;
            samples_next = samples_upd;
            coding_next  = coding_upd;
            datalen_next = datalen_upd;
            title_next   = title_upd;
            scalex_next  = scalex_upd;
            scaley_next  = scaley_upd;
        end
        else
        begin
            phase_next   = phase_reg;
            tag_next     = tag_reg;
            acc_next     = acc_reg;
            left_next    = left_reg;
            idx_next     = idx_reg;
            vi_next      = vi_reg;
            cap_next     = cap_reg;
            pos_next     = pos_reg;
            traces_next  = traces_reg;
            samples_next = samples_reg;
            coding_next  = coding_reg;
            datalen_next = datalen_reg;
            title_next   = title_reg;
            scalex_next  = scalex_reg;
            scaley_next  = scaley_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TAG;
            tag_reg     <= 8'd0;
            acc_reg     <= 32'd0;
            left_reg    <= 3'd0;
            idx_reg     <= 2'd0;
            vi_reg      <= 32'd0;
            cap_reg     <= 32'd0;
            pos_reg     <= '0;
            traces_reg  <= 32'd0;
            samples_reg <= 32'd0;
            coding_reg  <= CODING_RESET;
            datalen_reg <= 16'd0;
            title_reg   <= 8'd0;
            scalex_reg  <= 32'd0;
            scaley_reg  <= 32'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            tag_reg     <= tag_next;
            acc_reg     <= acc_next;
            left_reg    <= left_next;
            idx_reg     <= idx_next;
            vi_reg      <= vi_next;
            cap_reg     <= cap_next;
            pos_reg     <= pos_next;
            traces_reg  <= traces_next;
            samples_reg <= samples_next;
            coding_reg  <= coding_next;
            datalen_reg <= datalen_next;
            title_reg   <= title_next;
            scalex_reg  <= scalex_next;
            scaley_reg  <= scaley_next;
        end
    end

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        step && stream_end |=> phase_reg == PH_TAG && pos_reg == '0)
        else $error("parser state not cleared after final byte");

    a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> !emit)
        else $error("result raised after header already closed");

    a_ok_size_positive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == ST_OK |-> !res.trace_size[35] && res.trace_size != 36'sd0)
        else $error("ok result with nonpositive trace size");

    a_lenx_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LENX |-> left_reg != 3'd0 && left_reg <= 3'd4)
        else $error("length byte count out of range");

endmodule

`default_nettype wire

### rtl/tlv_trace_header_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Trace file header parser.
// Input stream (s_*): one header byte per beat in s_tdata, s_tlast on the final
// byte of the file. Records are tag, length (short byte or 1..4 little-endian
// long-form bytes), then value bytes; selected fields are captured as they end.
// Output stream (m_*): at most one beat per file, raised by the end tag 0x5F
// (status ok, or samples unset / trace size nonpositive) or by an error; status
// travels in m_tuser, the captured fields and computed trace size in m_tdata.
// Bytes after the result are dropped until s_tlast.
// Timing: an accepted byte is held in the input register, then parsed by one
// pass of logic into the output register, from which the result is presented.
// One byte per cycle is sustained while m_tready is high; the rate is set by
// the single parse stage.
// Stall: with m_tready low and a result held, one more byte is taken into the
// input register, then s_tready drops until the result is taken.
// Reset clears the parser to expect a tag; so does every s_tlast beat.
module tlv_trace_header_parser #(
    parameter int POSITION_BITS = tlvp_pkg::POSITION_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] header_byte
    input  wire logic         s_tlast,   // stream_end
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [231:0]      m_tdata,   // block_offset, trace_count, sample_count,
                                         // sample_bytes, sample_kind, data_len,
                                         // title_bytes, trace_size, scale_x_bits,
                                         // scale_y_bits, zero pad (lowest first)
    output logic [2:0]        m_tuser    // status
);
    import tlvp_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_res_reg;
    logic       advance;
    logic       res_valid;
    result_t    res;

    // Parse the held byte when the output register can take a result
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    tlvp_core #(
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .header_byte(in_byte_reg),
        .stream_end (in_last_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_comb
    begin
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {6'd0,
                       out_res_reg.scale_y_bits,
                       out_res_reg.scale_x_bits,
                       out_res_reg.trace_size,
                       out_res_reg.title_bytes,
                       out_res_reg.data_len,
                       out_res_reg.sample_kind,
                       out_res_reg.sample_bytes,
                       out_res_reg.sample_count,
                       out_res_reg.trace_count,
                       out_res_reg.block_offset};

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !advance)
        else $error("held result overwritten under stall");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("pending byte lost before parse");

    a_result_follows_parse: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid |=> m_tvalid)
        else $error("parsed result not presented");

endmodule

`default_nettype wire
